### rtl/rqbs_pkg.sv
// ----------------------------------------------------------------------------
// rqbs_pkg: shared types and constants of the ready queue burst scheduler
// Item layouts, event and status codes, slot conditions, register map and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rqbs_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int CFG_ADDR_BITS   = 4;
  localparam int EST_BITS        = 24;

  localparam logic [2:0] KIND_ADMIT  = 3'd0;
  localparam logic [2:0] KIND_TICK   = 3'd1;
  localparam logic [2:0] KIND_FINISH = 3'd2;
  localparam logic [2:0] KIND_BLOCK  = 3'd3;
  localparam logic [2:0] KIND_WAKE   = 3'd4;
  localparam logic [2:0] KIND_ABORT  = 3'd5;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;
  localparam logic [1:0] STAT_IDLE    = 2'd3;

  localparam logic [1:0] COND_READY   = 2'd0;
  localparam logic [1:0] COND_RUNNING = 2'd1;
  localparam logic [1:0] COND_BLOCKED = 2'd2;

  localparam logic [1:0] POL_FIFO     = 2'd0;
  localparam logic [1:0] POL_SHORTEST = 2'd1;
  localparam logic [1:0] POL_RATIO    = 2'd2;

  localparam logic [1:0] REG_POLICY   = 2'd0;
  localparam logic [1:0] REG_PREEMPT  = 2'd1;
  localparam logic [1:0] REG_ALPHA    = 2'd2;
  localparam logic [1:0] REG_INIT_EST = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] process_id;
  } in_item_t;

  typedef struct packed {
    logic [15:0] new_id;
    logic        running_valid;
    logic [15:0] running_id;
    logic        dispatched;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  policy;
    logic        preempt_on_arrival;
    logic [8:0]  alpha;
    logic [15:0] initial_estimate;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic clr_idx;
    logic inc_idx;
    logic find_chk;
    logic apply;
    logic sel_start;
    logic sel_mul;
    logic sel_cmp;
    logic dispatch;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_find;
    logic idx_last;
    logic sel_skip;
    logic stay_running;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/rqbs_ctrl.sv
// ----------------------------------------------------------------------------
// rqbs_ctrl: event sequencer
// Steps one event through the id search, the table update, the selection
// scan and the hand-off to the output register.
// ----------------------------------------------------------------------------
module rqbs_ctrl
  import rqbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_FIND_RD  = 9'b000000010,
    S_FIND_CHK = 9'b000000100,
    S_APPLY    = 9'b000001000,
    S_SEL_RD   = 9'b000010000,
    S_SEL_MUL  = 9'b000100000,
    S_SEL_CMP  = 9'b001000000,
    S_SEL_DONE = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.clr_idx = 1'b1;
          state_next = st.needs_find ? S_FIND_RD : S_APPLY;
        end
      end
      S_FIND_RD: begin
        state_next = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        cmd.find_chk = 1'b1;
        if (st.idx_last) begin
          state_next = S_APPLY;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next = S_FIND_RD;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        cmd.clr_idx = 1'b1;
        cmd.sel_start = 1'b1;
        state_next = st.stay_running ? S_FINISH : S_SEL_RD;
      end
      S_SEL_RD: begin
        if (st.sel_skip) begin
          if (st.idx_last) begin
            state_next = S_SEL_DONE;
          end else begin
            cmd.inc_idx = 1'b1;
          end
        end else begin
          state_next = S_SEL_MUL;
        end
      end
      S_SEL_MUL: begin
        cmd.sel_mul = 1'b1;
        state_next = S_SEL_CMP;
      end
      S_SEL_CMP: begin
        cmd.sel_cmp = 1'b1;
        if (st.idx_last) begin
          state_next = S_SEL_DONE;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next = S_SEL_RD;
        end
      end
      S_SEL_DONE: begin
        cmd.dispatch = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/rqbs_dp.sv
// ----------------------------------------------------------------------------
// rqbs_dp: process table and scheduling datapath
// Holds the slot table, the running process, the counters, the selection
// comparator with its two ratio multipliers and the output register.
// ----------------------------------------------------------------------------
module rqbs_dp
  import rqbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
)(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  in_item_t   in_item,
  input  ctrl_cmd_t  cmd,
  output dp_status_t st,
  input  logic       out_stall,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int IW = $clog2(TABLE_DEPTH);

  logic [2:0]          kind;
  logic [ID_BITS-1:0]  pid;
  logic [IW-1:0]       idx;

  logic                used [TABLE_DEPTH];
  logic [1:0]          cond [TABLE_DEPTH];
  logic [ID_BITS-1:0]  mem_pid   [TABLE_DEPTH];
  logic [EST_BITS-1:0] mem_est   [TABLE_DEPTH];
  logic [31:0]         mem_since [TABLE_DEPTH];
  logic [31:0]         mem_order [TABLE_DEPTH];
  logic [ID_BITS-1:0]  rd_pid;
  logic [EST_BITS-1:0] rd_est;
  logic [31:0]         rd_since;
  logic [31:0]         rd_order;

  logic                run_valid;
  logic [IW-1:0]       run_slot;
  logic [ID_BITS-1:0]  run_pid;
  logic [EST_BITS-1:0] run_est;
  logic [15:0]         burst_ticks;
  logic [31:0]         tick_clock;
  logic [ID_BITS-1:0]  next_pid;
  logic [31:0]         order_counter;
  logic                arrival_pending;

  logic                free_found, blk_found, any_found;
  logic [IW-1:0]       free_slot, blk_slot, any_slot;

  logic                found;
  logic [IW-1:0]       best_idx, c_idx;
  logic [ID_BITS-1:0]  best_pid, c_pid;
  logic [EST_BITS-1:0] best_est, c_est;
  logic [31:0]         best_since, c_since, best_order, c_order;
  logic [55:0]         prod_c, prod_b;

  logic [ID_BITS-1:0]  new_id;
  logic                dispatched;
  logic [1:0]          status;

  logic [31:0]         pid_wide;
  logic [31:0]         run_pid_wide, new_id_wide;
  logic [15:0]         bt_tick, bt_eff;
  logic [8:0]          a_eff, a_inv;
  logic [33:0]         avg_sum;
  logic [EST_BITS-1:0] burst_est;
  logic [ID_BITS-1:0]  npid_inc;
  logic [31:0]         tick_inc;
  logic [31:0]         w_c, w_b, age_c, age_b;
  logic                beats, win;

  logic                rv_next, ap_next;
  logic [15:0]         bt_next;
  logic [31:0]         tick_next, oc_next;
  logic [ID_BITS-1:0]  npid_next, new_id_next;
  logic [1:0]          status_next;
  logic [IW-1:0]       wr_addr, used_addr, cond_addr;
  logic                wr_pid_en, wr_est_en, wr_tim_en;
  logic [ID_BITS-1:0]  wr_pid;
  logic [EST_BITS-1:0] wr_est;
  logic [31:0]         wr_since, wr_order;
  logic                used_set, used_clr, cond_en;
  logic [1:0]          cond_val;

  assign pid_wide     = 32'(in_item.process_id);
  assign run_pid_wide = 32'(run_pid);
  assign new_id_wide  = 32'(new_id);

  assign st.needs_find   = (in_item.kind == KIND_ADMIT) || (in_item.kind == KIND_WAKE) ||
                           (in_item.kind == KIND_ABORT);
  assign st.idx_last     = (idx == IW'(TABLE_DEPTH - 1));
  assign st.sel_skip     = !(used[idx] && (cond[idx] == COND_READY));
  assign st.stay_running = rv_next;
  assign st.out_free     = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (wr_pid_en) begin
      mem_pid[wr_addr] <= wr_pid;
    end
    if (wr_est_en) begin
      mem_est[wr_addr] <= wr_est;
    end
    if (wr_tim_en) begin
      mem_since[wr_addr] <= wr_since;
      mem_order[wr_addr] <= wr_order;
    end
    rd_pid   <= mem_pid[idx];
    rd_est   <= mem_est[idx];
    rd_since <= mem_since[idx];
    rd_order <= mem_order[idx];
  end

  assign bt_tick   = (burst_ticks == 16'hFFFF) ? burst_ticks : burst_ticks + 16'd1;
  assign bt_eff    = (kind == KIND_TICK) ? bt_tick : burst_ticks;
  assign a_eff     = (cfg.alpha > 9'd256) ? 9'd256 : cfg.alpha;
  assign a_inv     = 9'd256 - a_eff;
  assign avg_sum   = 34'(a_eff) * 34'({bt_eff, 8'b0}) + 34'(a_inv) * 34'(run_est);
  assign burst_est = avg_sum[31:8];
  assign npid_inc  = next_pid + ID_BITS'(1);
  assign tick_inc  = tick_clock + 32'd1;

  always_comb begin
    rv_next     = run_valid;
    ap_next     = arrival_pending;
    bt_next     = burst_ticks;
    tick_next   = tick_clock;
    oc_next     = order_counter;
    npid_next   = next_pid;
    new_id_next = '0;
    status_next = STAT_OK;
    wr_addr     = run_slot;
    wr_pid_en   = 1'b0;
    wr_est_en   = 1'b0;
    wr_tim_en   = 1'b0;
    wr_pid      = next_pid;
    wr_est      = burst_est;
    wr_since    = tick_clock;
    wr_order    = order_counter;
    used_set    = 1'b0;
    used_clr    = 1'b0;
    used_addr   = run_slot;
    cond_en     = 1'b0;
    cond_val    = COND_READY;
    cond_addr   = run_slot;
    case (kind)
      KIND_ADMIT: begin
        if (!free_found) begin
          status_next = STAT_FULL;
        end else begin
          used_set    = 1'b1;
          used_addr   = free_slot;
          cond_en     = 1'b1;
          cond_addr   = free_slot;
          wr_addr     = free_slot;
          wr_pid_en   = 1'b1;
          wr_est_en   = 1'b1;
          wr_tim_en   = 1'b1;
          wr_est      = {cfg.initial_estimate, 8'b0};
          oc_next     = order_counter + 32'd1;
          new_id_next = next_pid;
          npid_next   = (npid_inc == '0) ? ID_BITS'(1) : npid_inc;
          ap_next     = run_valid;
        end
      end
      KIND_TICK: begin
        if (!run_valid) begin
          status_next = STAT_IDLE;
        end else begin
          tick_next = tick_inc;
          bt_next   = bt_tick;
          if (cfg.preempt_on_arrival && arrival_pending) begin
            wr_est_en = 1'b1;
            wr_tim_en = 1'b1;
            wr_since  = tick_inc;
            cond_en   = 1'b1;
            oc_next   = order_counter + 32'd1;
            rv_next   = 1'b0;
            ap_next   = 1'b0;
          end
        end
      end
      KIND_FINISH: begin
        if (!run_valid) begin
          status_next = STAT_IDLE;
        end else begin
          used_clr = 1'b1;
          rv_next  = 1'b0;
          bt_next  = '0;
        end
      end
      KIND_BLOCK: begin
        if (!run_valid) begin
          status_next = STAT_IDLE;
        end else begin
          wr_est_en = 1'b1;
          cond_en   = 1'b1;
          cond_val  = COND_BLOCKED;
          rv_next   = 1'b0;
          bt_next   = '0;
        end
      end
      KIND_WAKE: begin
        if (blk_found) begin
          cond_en   = 1'b1;
          cond_addr = blk_slot;
          wr_addr   = blk_slot;
          wr_tim_en = 1'b1;
          oc_next   = order_counter + 32'd1;
        end else if (!any_found) begin
          status_next = STAT_UNKNOWN;
        end
      end
      KIND_ABORT: begin
        if (!any_found) begin
          status_next = STAT_UNKNOWN;
        end else begin
          used_clr  = 1'b1;
          used_addr = any_slot;
          if (run_valid && (run_slot == any_slot)) begin
            rv_next = 1'b0;
            bt_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
    if (!cmd.apply) begin
      wr_pid_en = 1'b0;
      wr_est_en = 1'b0;
      wr_tim_en = 1'b0;
    end
  end

  assign w_c   = tick_clock - rd_since;
  assign w_b   = tick_clock - best_since;
  assign age_c = order_counter - c_order;
  assign age_b = order_counter - best_order;

  always_comb begin
    beats = (age_c > age_b);
    case (cfg.policy)
      POL_SHORTEST: begin
        if (c_est != best_est) begin
          beats = (c_est < best_est);
        end
      end
      POL_RATIO: begin
        if (prod_c != prod_b) begin
          beats = (prod_c > prod_b);
        end
      end
      default: begin
      end
    endcase
  end

  assign win = !found || beats;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind <= in_item.kind;
      pid  <= pid_wide[ID_BITS-1:0];
    end
    if (cmd.find_chk) begin
      if (!used[idx]) begin
        if (!free_found) begin
          free_slot <= idx;
        end
      end else if (rd_pid == pid) begin
        if (!any_found) begin
          any_slot <= idx;
        end
        if (!blk_found && (cond[idx] == COND_BLOCKED)) begin
          blk_slot <= idx;
        end
      end
    end
    if (cmd.apply && cond_en) begin
      cond[cond_addr] <= cond_val;
    end else if (cmd.dispatch && found) begin
      cond[best_idx] <= COND_RUNNING;
    end
    if (cmd.sel_mul) begin
      c_idx   <= idx;
      c_pid   <= rd_pid;
      c_est   <= rd_est;
      c_since <= rd_since;
      c_order <= rd_order;
      prod_c  <= 56'(w_c) * 56'(best_est);
      prod_b  <= 56'(w_b) * 56'(rd_est);
    end
    if (cmd.sel_cmp && win) begin
      best_idx   <= c_idx;
      best_pid   <= c_pid;
      best_est   <= c_est;
      best_since <= c_since;
      best_order <= c_order;
    end
    if (cmd.apply) begin
      new_id <= new_id_next;
      status <= status_next;
    end
    if (cmd.load_out) begin
      out_item.new_id        <= new_id_wide[15:0];
      out_item.running_valid <= run_valid;
      out_item.running_id    <= run_valid ? run_pid_wide[15:0] : 16'd0;
      out_item.dispatched    <= dispatched;
      out_item.status        <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        used[i] <= 1'b0;
      end
      idx             <= '0;
      run_valid       <= 1'b0;
      run_slot        <= '0;
      run_pid         <= '0;
      run_est         <= '0;
      burst_ticks     <= '0;
      tick_clock      <= '0;
      next_pid        <= ID_BITS'(1);
      order_counter   <= '0;
      arrival_pending <= 1'b0;
      free_found      <= 1'b0;
      blk_found       <= 1'b0;
      any_found       <= 1'b0;
      found           <= 1'b0;
      dispatched      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + IW'(1);
      end
      if (cmd.capture) begin
        free_found <= 1'b0;
        blk_found  <= 1'b0;
        any_found  <= 1'b0;
        dispatched <= 1'b0;
      end
      if (cmd.find_chk) begin
        if (!used[idx]) begin
          free_found <= 1'b1;
        end else if (rd_pid == pid) begin
          any_found <= 1'b1;
          if (cond[idx] == COND_BLOCKED) begin
            blk_found <= 1'b1;
          end
        end
      end
      if (cmd.apply) begin
        if (used_set) begin
          used[used_addr] <= 1'b1;
        end else if (used_clr) begin
          used[used_addr] <= 1'b0;
        end
        run_valid       <= rv_next;
        burst_ticks     <= bt_next;
        tick_clock      <= tick_next;
        order_counter   <= oc_next;
        next_pid        <= npid_next;
        arrival_pending <= ap_next;
        if (wr_est_en) begin
          run_est <= burst_est;
        end
      end
      if (cmd.sel_start) begin
        found <= 1'b0;
      end else if (cmd.sel_cmp) begin
        found <= 1'b1;
      end
      if (cmd.dispatch && found) begin
        run_valid   <= 1'b1;
        run_slot    <= best_idx;
        run_pid     <= best_pid;
        run_est     <= best_est;
        burst_ticks <= '0;
        dispatched  <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/ready_queue_burst_scheduler.sv
// ----------------------------------------------------------------------------
// ready_queue_burst_scheduler: process table with FIFO, SJF and HRRN pick
// Top level with the register file, the event sequencer and the datapath.
//
//   Channel   Handshake                Beat
//   in        in_valid / in_stall      in_item (kind, process_id)
//   out       out_valid / out_stall    out_item (one result per event)
//   config    psel/penable/pwrite      pwdata at paddr, prdata on reads
//
// An admit, wake or abort first scans every slot for its id or a free slot,
// with a read and a check state per slot. With no process running afterwards,
// the selection scan skips idle slots in its read state and takes ready slots
// through the multiply and compare states, the ratio multipliers coming before
// the compare. The table update, dispatch and output load each have a state.
// Reset is synchronous and leaves the table empty. A stalled output holds its
// beat while the next event is already accepted and worked on.
// ----------------------------------------------------------------------------
module ready_queue_burst_scheduler
  import rqbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
)(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_item,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       busy;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy             <= POL_FIFO;
      cfg.preempt_on_arrival <= 1'b0;
      cfg.alpha              <= 9'd128;
      cfg.initial_estimate   <= 16'd5;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_POLICY:   cfg.policy             <= pwdata[1:0];
        REG_PREEMPT:  cfg.preempt_on_arrival <= pwdata[0];
        REG_ALPHA:    cfg.alpha              <= pwdata[8:0];
        REG_INIT_EST: cfg.initial_estimate   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POLICY:   prdata = 32'(cfg.policy);
      REG_PREEMPT:  prdata = 32'(cfg.preempt_on_arrival);
      REG_ALPHA:    prdata = 32'(cfg.alpha);
      REG_INIT_EST: prdata = 32'(cfg.initial_estimate);
      default:      prdata = '0;
    endcase
  end

  assign in_stall = busy;

  rqbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  rqbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("event accepted but sequencer did not go busy");

  a_dispatch_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_item.dispatched || out_item.running_valid))
    else $error("dispatch reported with nothing running");

  a_fail_no_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != STAT_OK) |-> (out_item.new_id == 16'd0))
    else $error("id reported on a failed event");

endmodule
